/* sv/integer_to_ascii_digit_formatter_core_macros.svh */
// Assertion macros used by the checker file of the digit formatter.
`ifndef INTEGER_TO_ASCII_DIGIT_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_DIGIT_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset
`define ITOA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/itoa_pkg.sv */
// Types, constants and decode functions for the integer to ASCII digit formatter.
package itoa_pkg;

  localparam int VAL_W              = 64;
  localparam int FMT_W              = 4;
  localparam int CHAR_W             = 7;
  localparam int OUT_DATA_W         = 8;
  localparam int CNT_W              = 7;
  localparam int DIGIT_W            = 4;
  localparam int BCD_DIGITS         = 20;
  localparam int BCD_W              = BCD_DIGITS * DIGIT_W;
  localparam int DEC16_DIGITS       = 5;
  localparam int DEC32_DIGITS       = 10;
  localparam int DEF_MAX_VALUE_BITS = 64;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER = 7'h37;
  localparam logic [CHAR_W-1:0]  ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_F     = 7'h46;
  localparam logic [DIGIT_W-1:0] DEC_RADIX   = 4'd10;

  // format codes on in_tuser; codes above the last member are invalid
  typedef enum logic [FMT_W-1:0] {
    FMT_HEX16 = 4'd0,
    FMT_HEX32 = 4'd1,
    FMT_HEX64 = 4'd2,
    FMT_BIN8  = 4'd3,
    FMT_BIN16 = 4'd4,
    FMT_BIN32 = 4'd5,
    FMT_BIN64 = 4'd6,
    FMT_DEC16 = 4'd7,
    FMT_DEC32 = 4'd8,
    FMT_DEC64 = 4'd9
  } fmt_code_t;

  typedef enum logic [1:0] {
    KIND_HEX,
    KIND_BIN,
    KIND_DEC,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] digits;
    logic [CNT_W-1:0] width;
  } fmt_desc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_EMIT,
    ST_BAD
  } state_t;

  // BCD register operations
  typedef enum logic [2:0] {
    DB_HOLD,
    DB_CLEAR,
    DB_SHIFT_IN,
    DB_ALIGN,
    DB_EMIT
  } dab_op_t;

  // decimal string length, picks the alignment of the BCD register
  typedef enum logic [1:0] {
    DSEL_5,
    DSEL_10,
    DSEL_20
  } dec_sel_t;

  typedef struct packed {
    dab_op_t  op;
    logic     bit_in;
    dec_sel_t sel;
  } dab_ctl_t;

  function automatic fmt_desc_t fmt_decode(input logic [FMT_W-1:0] code);
    fmt_desc_t d;
    unique case (code)
      FMT_HEX16: d = '{KIND_HEX, 7'd4,  7'd16};
      FMT_HEX32: d = '{KIND_HEX, 7'd8,  7'd32};
      FMT_HEX64: d = '{KIND_HEX, 7'd16, 7'd64};
      FMT_BIN8:  d = '{KIND_BIN, 7'd8,  7'd8};
      FMT_BIN16: d = '{KIND_BIN, 7'd16, 7'd16};
      FMT_BIN32: d = '{KIND_BIN, 7'd32, 7'd32};
      FMT_BIN64: d = '{KIND_BIN, 7'd64, 7'd64};
      FMT_DEC16: d = '{KIND_DEC, 7'd5,  7'd16};
      FMT_DEC32: d = '{KIND_DEC, 7'd10, 7'd32};
      FMT_DEC64: d = '{KIND_DEC, 7'd20, 7'd64};
      default:   d = '{KIND_BAD, 7'd1,  7'd0};
    endcase
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_RADIX) begin
      c = CHAR_W'(d) + ASCII_ZERO;
    end else begin
      c = CHAR_W'(d) + ASCII_UPPER;
    end
    return c;
  endfunction

endpackage

/* sv/itoa_dabble.sv */
// Bit-serial binary to BCD converter (shift and add-3) that also shifts out its digits.
module itoa_dabble import itoa_pkg::*; (
  input  logic               clk,
  input  dab_ctl_t           ctl,
  output logic [DIGIT_W-1:0] top_digit
);

  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_nxt;
  logic [BCD_W-1:0] adj;

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // register operation decode
  always_comb begin
    unique case (ctl.op)
      DB_HOLD:     bcd_nxt = bcd_r;
      DB_CLEAR:    bcd_nxt = '0;
      DB_SHIFT_IN: bcd_nxt = {adj[BCD_W-2:0], ctl.bit_in};
      DB_ALIGN: begin
        // bring the most significant digit of the string to the top
        unique case (ctl.sel)
          DSEL_5:  bcd_nxt = bcd_r << ((BCD_DIGITS - DEC16_DIGITS) * DIGIT_W);
          DSEL_10: bcd_nxt = bcd_r << ((BCD_DIGITS - DEC32_DIGITS) * DIGIT_W);
          default: bcd_nxt = bcd_r;
        endcase
      end
      DB_EMIT:     bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      default:     bcd_nxt = bcd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule

/* sv/integer_to_ascii_digit_formatter_core.sv */
// Integer to ASCII digit formatter: one value in, its fixed-width digit string out, MSD first.
//
// Each accepted item is formatted as hexadecimal, binary or decimal with leading zeros kept,
// one character per output transfer, the final character marked on out_tlast. An invalid
// format code gives a single transfer with character 0 and out_tuser set. One item is worked
// at a time: hex and binary characters are shifted straight out of the value; decimal first runs
// the value through a one-bit-per-cycle shift-and-add-3 converter, then aligns the BCD digits
// and shifts them out. The next item is taken as soon as the last character sits in the single
// character output register. Only the low MAX_VALUE_BITS of the value are kept.
module integer_to_ascii_digit_formatter_core import itoa_pkg::*; #(
  parameter int MAX_VALUE_BITS = DEF_MAX_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // [63:0] value
  input  logic [FMT_W-1:0]      in_tuser,   // [3:0] format_code
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [6:0] ascii_char, [7] zero
  output logic                  out_tlast,
  output logic                  out_tuser   // [0] bad_format
);

  state_t               state_r, state_nxt;
  logic [FMT_W-1:0]     fmt_r, fmt_nxt;
  logic [VAL_W-1:0]     sh_r, sh_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_bad_r, out_bad_nxt;

  fmt_desc_t            desc_in;
  fmt_desc_t            desc_r;
  logic [VAL_W-1:0]     val_kept;
  logic [VAL_W-1:0]     val_aligned;
  logic [DIGIT_W-1:0]   dec_digit;
  logic [DIGIT_W-1:0]   cur_digit;
  logic                 ld_ok;
  dab_ctl_t             dab_ctl;
  dec_sel_t             dsel;

  assign desc_in = fmt_decode(in_tuser);
  assign desc_r  = fmt_decode(fmt_r);

  // drop value bits the block does not keep
  assign val_kept = VAL_W'(in_tdata[MAX_VALUE_BITS-1:0]);

  // left-align the value so its top format bit sits at the register top
  always_comb begin
    case (in_tuser) inside
      FMT_BIN8:                       val_aligned = val_kept << (VAL_W - 8);
      FMT_HEX16, FMT_BIN16, FMT_DEC16: val_aligned = val_kept << (VAL_W - 16);
      FMT_HEX32, FMT_BIN32, FMT_DEC32: val_aligned = val_kept << (VAL_W - 32);
      default:                        val_aligned = val_kept;
    endcase
  end

  // decimal string length
  always_comb begin
    case (fmt_r) inside
      FMT_DEC16: dsel = DSEL_5;
      FMT_DEC32: dsel = DSEL_10;
      default:   dsel = DSEL_20;
    endcase
  end

  // current digit at the head of the selected shift register
  always_comb begin
    case (desc_r.kind)
      KIND_HEX: cur_digit = sh_r[VAL_W-1 -: DIGIT_W];
      KIND_BIN: cur_digit = DIGIT_W'(sh_r[VAL_W-1]);
      default:  cur_digit = dec_digit;
    endcase
  end

  assign ld_ok     = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // sequencer: next state, shift control and output register load
  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    dab_ctl       = '{DB_HOLD, sh_r[VAL_W-1], dsel};

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          fmt_nxt = in_tuser;
          sh_nxt  = val_aligned;
          if (desc_in.kind == KIND_BAD) begin
            state_nxt = ST_BAD;
          end else if (desc_in.kind == KIND_DEC) begin
            dab_ctl.op = DB_CLEAR;
            cnt_nxt    = desc_in.width;
            state_nxt  = ST_CONV;
          end else begin
            cnt_nxt   = desc_in.digits;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        dab_ctl.op = DB_SHIFT_IN;
        sh_nxt     = sh_r << 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        dab_ctl.op = DB_ALIGN;
        cnt_nxt    = desc_r.digits;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (ld_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_ascii(cur_digit);
          out_last_nxt  = (cnt_r == CNT_W'(1));
          out_bad_nxt   = 1'b0;
          cnt_nxt       = cnt_r - CNT_W'(1);
          case (desc_r.kind)
            KIND_HEX: sh_nxt = sh_r << DIGIT_W;
            KIND_BIN: sh_nxt = sh_r << 1;
            default:  dab_ctl.op = DB_EMIT;
          endcase
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BAD: begin
        if (ld_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    fmt_r      <= fmt_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  itoa_dabble u_dabble (
    .clk       (clk),
    .ctl       (dab_ctl),
    .top_digit (dec_digit)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_char_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

endmodule

/* sv/itoa_checker.sv */
// Port-level assertion checker for the digit formatter, bound to the top level.
`include "integer_to_ascii_digit_formatter_core_macros.svh"

module itoa_checker import itoa_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  logic out_is_digit;

  // character lies in 0-9 or A-F
  assign out_is_digit =
    (out_tdata >= OUT_DATA_W'(ASCII_ZERO) && out_tdata <= OUT_DATA_W'(ASCII_NINE)) ||
    (out_tdata >= OUT_DATA_W'(ASCII_A) && out_tdata <= OUT_DATA_W'(ASCII_F));

  // an invalid format gives one transfer that also ends the string
  `ITOA_ASSERT_IMPL(a_bad_is_last, out_tvalid && out_tuser, out_tlast, "bad format not last")

  // the flagged transfer carries character zero
  `ITOA_ASSERT_IMPL(a_bad_char_zero, out_tvalid && out_tuser, out_tdata == '0, "bad format char")

  // every normal character is 0-9 or A-F
  `ITOA_ASSERT_IMPL(a_char_is_digit, out_tvalid && !out_tuser, out_is_digit, "not a digit")

  // a stalled result stays put
  `ITOA_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

endmodule

bind integer_to_ascii_digit_formatter_core itoa_checker u_itoa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
